// ----- rtl/vrts_pkg.sv -----
// Shared widths, codes and register indexes for the velocity-rescale scale core.
package vrts_pkg;

    localparam int ENERGY_WIDTH_DEF = 32;
    localparam int NOISE_WIDTH      = 16;
    localparam int RELAX_WIDTH      = 16;
    localparam int NGAIN_WIDTH      = 20;
    localparam int SCALE_WIDTH      = 18;
    localparam int STATUS_WIDTH     = 2;
    localparam int MAG_WIDTH        = 36;
    localparam int MAG_HALF         = MAG_WIDTH / 2;
    localparam int QUOT_WIDTH       = 2 * SCALE_WIDTH;
    localparam int FRAC_BITS        = 32;
    localparam int NOISE_SHIFT      = 28;
    localparam int INDEX_WIDTH      = 2;

    localparam logic [SCALE_WIDTH-1:0] SCALE_MAX = '1;

    typedef enum logic [STATUS_WIDTH-1:0] {
        STATUS_OK     = 2'd0,
        STATUS_ZERO_K = 2'd1,
        STATUS_NEG_K  = 2'd2
    } status_t;

    localparam logic [INDEX_WIDTH-1:0] REG_REF_KINETIC = 2'd0;
    localparam logic [INDEX_WIDTH-1:0] REG_RELAX_GAIN  = 2'd1;
    localparam logic [INDEX_WIDTH-1:0] REG_NOISE_GAIN  = 2'd2;

endpackage

// ----- rtl/vrts_sqrt_pipe.sv -----
// Pipelined integer square root, one root bit per stage, payload carried alongside.
module vrts_sqrt_pipe #(
    parameter int RW = 18,
    parameter int PW = 1
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  logic [2*RW-1:0] in_rad,
    input  logic [PW-1:0]   in_pay,
    output logic            out_valid,
    output logic [RW-1:0]   out_root,
    output logic [PW-1:0]   out_pay
);

    logic            valid_reg [RW];
    logic [2*RW-1:0] rad_reg   [RW];
    logic [RW:0]     rem_reg   [RW];
    logic [RW-1:0]   root_reg  [RW];
    logic [PW-1:0]   pay_reg   [RW];

    for (genvar i = 0; i < RW; i++) begin : g_stage
        logic            v_in;
        logic [2*RW-1:0] rad_in;
        logic [RW:0]     rem_in;
        logic [RW-1:0]   root_in;
        logic [PW-1:0]   pay_in;
        logic [RW+2:0]   rem_sh;
        logic [RW+2:0]   trial;
        logic [RW+2:0]   diff;

        if (i == 0) begin : g_first
            assign v_in    = in_valid;
            assign rad_in  = in_rad;
            assign rem_in  = '0;
            assign root_in = '0;
            assign pay_in  = in_pay;
        end else begin : g_next
            assign v_in    = valid_reg[i-1];
            assign rad_in  = rad_reg[i-1];
            assign rem_in  = rem_reg[i-1];
            assign root_in = root_reg[i-1];
            assign pay_in  = pay_reg[i-1];
        end

        // bring down two radicand bits and try the next root bit
        assign rem_sh = {rem_in, rad_in[2*RW-1 -: 2]};
        assign trial  = {1'b0, root_in, 2'b01};
        assign diff   = rem_sh - trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[i] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rad_reg[i] <= rad_in << 2;
                pay_reg[i] <= pay_in;
                if (rem_sh >= trial)
                begin
                    rem_reg[i]  <= diff[RW:0];
                    root_reg[i] <= {root_in[RW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[i]  <= rem_sh[RW:0];
                    root_reg[i] <= {root_in[RW-2:0], 1'b0};
                end
            end
        end
    end

    assign out_valid = valid_reg[RW-1];
    assign out_root  = root_reg[RW-1];
    assign out_pay   = pay_reg[RW-1];

endmodule

// ----- rtl/vrts_div_pipe.sv -----
// Pipelined restoring divider, one quotient bit per stage.
module vrts_div_pipe #(
    parameter int DW = 32,
    parameter int QW = 36,
    parameter int PW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [DW-1:0] in_rem,
    input  logic [QW-1:0] in_low,
    input  logic [DW-1:0] in_div,
    input  logic [PW-1:0] in_pay,
    output logic          out_valid,
    output logic [QW-1:0] out_quot,
    output logic [PW-1:0] out_pay
);

    logic          valid_reg [QW];
    logic [DW-1:0] rem_reg   [QW];
    logic [QW-1:0] low_reg   [QW];
    logic [QW-1:0] quot_reg  [QW];
    logic [DW-1:0] div_reg   [QW];
    logic [PW-1:0] pay_reg   [QW];

    for (genvar i = 0; i < QW; i++) begin : g_stage
        logic          v_in;
        logic [DW-1:0] rem_in;
        logic [QW-1:0] low_in;
        logic [QW-1:0] quot_in;
        logic [DW-1:0] div_in;
        logic [PW-1:0] pay_in;
        logic [DW:0]   trial;
        logic [DW:0]   diff;
        logic          fits;

        if (i == 0) begin : g_first
            assign v_in    = in_valid;
            assign rem_in  = in_rem;
            assign low_in  = in_low;
            assign quot_in = '0;
            assign div_in  = in_div;
            assign pay_in  = in_pay;
        end else begin : g_next
            assign v_in    = valid_reg[i-1];
            assign rem_in  = rem_reg[i-1];
            assign low_in  = low_reg[i-1];
            assign quot_in = quot_reg[i-1];
            assign div_in  = div_reg[i-1];
            assign pay_in  = pay_reg[i-1];
        end

        // shift in the next numerator bit and subtract where it fits
        assign trial = {rem_in, low_in[QW-1]};
        assign diff  = trial - {1'b0, div_in};
        assign fits  = trial >= {1'b0, div_in};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[i] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i]  <= fits ? diff[DW-1:0] : trial[DW-1:0];
                low_reg[i]  <= low_in << 1;
                quot_reg[i] <= {quot_in[QW-2:0], fits};
                div_reg[i]  <= div_in;
                pay_reg[i]  <= pay_in;
            end
        end
    end

    assign out_valid = valid_reg[QW-1];
    assign out_quot  = quot_reg[QW-1];
    assign out_pay   = pay_reg[QW-1];

endmodule

// ----- rtl/velocity_rescale_thermostat_scale_core.sv -----
// One item per cycle unless a result is held; each root or divider stage yields one result bit.
// The whole pipeline holds while a result waits on m_axis_tready; nothing is dropped or repeated.
// Reset clears the pipeline valid bits, the output valid bit and all three config registers.
// Config is taken at once on cfg_wr_en; an unknown index is ignored.
module velocity_rescale_thermostat_scale_core #(
    parameter int ENERGY_WIDTH = vrts_pkg::ENERGY_WIDTH_DEF
) (
    input  logic clk,
    input  logic rst_n,
    // fields from bit 0: kinetic_energy, noise_sample, zero fill
    input  logic [((ENERGY_WIDTH + vrts_pkg::NOISE_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // fields from bit 0: scale_factor, status, zero fill
    output logic [23:0] m_axis_tdata,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    input  logic cfg_wr_en,
    input  logic [vrts_pkg::INDEX_WIDTH-1:0] cfg_index,
    input  logic [(ENERGY_WIDTH > vrts_pkg::NGAIN_WIDTH ? ENERGY_WIDTH
                   : vrts_pkg::NGAIN_WIDTH) - 1:0] cfg_wdata
);
    import vrts_pkg::*;

    localparam int W    = ENERGY_WIDTH;
    localparam int NKW  = W + 10;
    localparam int SPW  = 2 * W + MAG_WIDTH + 3;
    localparam int DPW  = STATUS_WIDTH + 1;

    logic adv;

    logic [W-1:0]           ref_kinetic_reg;
    logic [RELAX_WIDTH-1:0] relax_gain_reg;
    logic [NGAIN_WIDTH-1:0] noise_gain_reg;

    // write config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_kinetic_reg <= '0;
            relax_gain_reg  <= '0;
            noise_gain_reg  <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_REF_KINETIC: ref_kinetic_reg <= cfg_wdata[W-1:0];
                REG_RELAX_GAIN:  relax_gain_reg  <= cfg_wdata[RELAX_WIDTH-1:0];
                REG_NOISE_GAIN:  noise_gain_reg  <= cfg_wdata[NGAIN_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    // advance every stage unless a result is held at the output
    logic out_valid_reg;
    assign adv           = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = adv;

    // stage A: capture item, take noise magnitude
    logic                 a_valid_reg;
    logic [W-1:0]         a_k_reg;
    logic                 a_nneg_reg;
    logic [NOISE_WIDTH:0] a_nmag_reg;
    logic [NOISE_WIDTH-1:0] noise_in;
    logic [NOISE_WIDTH:0]   nmag_next;

    assign noise_in  = s_axis_tdata[W +: NOISE_WIDTH];
    assign nmag_next = noise_in[NOISE_WIDTH-1]
                     ? ({1'b1, {NOISE_WIDTH{1'b0}}} - {1'b0, noise_in})
                     : {1'b0, noise_in};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_k_reg    <= s_axis_tdata[W-1:0];
            a_nneg_reg <= noise_in[NOISE_WIDTH-1];
            a_nmag_reg <= nmag_next;
        end
    end

    // stage B: R*K for the root, relax term, noise magnitude times gain
    logic                 b_valid_reg;
    logic [2*W-1:0]       b_rk_reg;
    logic [SPW-1:0]       b_pay_reg;
    logic                 rge;
    logic [W-1:0]         diff_k;
    logic [W+RELAX_WIDTH-1:0] relax_prod;
    logic [NOISE_WIDTH+NGAIN_WIDTH:0] mag_prod;

    assign rge        = ref_kinetic_reg >= a_k_reg;
    assign diff_k     = rge ? (ref_kinetic_reg - a_k_reg) : (a_k_reg - ref_kinetic_reg);
    assign relax_prod = diff_k * relax_gain_reg;
    assign mag_prod   = a_nmag_reg * noise_gain_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_rk_reg  <= ref_kinetic_reg * a_k_reg;
            b_pay_reg <= {a_k_reg, relax_prod[W+RELAX_WIDTH-1:RELAX_WIDTH], rge, a_nneg_reg,
                          mag_prod[MAG_WIDTH-1:0], (a_k_reg == '0)};
        end
    end

    // root of R*K
    logic           r_valid;
    logic [W-1:0]   r_root;
    logic [SPW-1:0] r_pay;

    vrts_sqrt_pipe #(
        .RW (W),
        .PW (SPW)
    ) u_root_rk (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (b_valid_reg),
        .in_rad    (b_rk_reg),
        .in_pay    (b_pay_reg),
        .out_valid (r_valid),
        .out_root  (r_root),
        .out_pay   (r_pay)
    );

    logic [W-1:0]          r_k;
    logic [W-1:0]          r_d1;
    logic                  r_rge;
    logic                  r_nneg;
    logic [MAG_WIDTH-1:0]  r_mag;
    logic                  r_zero;
    assign {r_k, r_d1, r_rge, r_nneg, r_mag, r_zero} = r_pay;

    // stage C: root times noise magnitude as two half products
    logic                  c_valid_reg;
    logic [W+MAG_HALF-1:0] c_plo_reg;
    logic [W+MAG_HALF-1:0] c_phi_reg;
    logic [W-1:0]          c_k_reg;
    logic [W-1:0]          c_d1_reg;
    logic                  c_rge_reg;
    logic                  c_nneg_reg;
    logic                  c_zero_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            c_valid_reg <= r_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c_plo_reg  <= r_root * r_mag[MAG_HALF-1:0];
            c_phi_reg  <= r_root * r_mag[MAG_WIDTH-1:MAG_HALF];
            c_k_reg    <= r_k;
            c_d1_reg   <= r_d1;
            c_rge_reg  <= r_rge;
            c_nneg_reg <= r_nneg;
            c_zero_reg <= r_zero;
        end
    end

    // stage D: sum the noise term and form the new energy
    logic                  d_valid_reg;
    logic [NKW-1:0]        d_newk_reg;
    logic [W-1:0]          d_k_reg;
    logic                  d_zero_reg;
    logic [W+MAG_WIDTH-1:0] d2_full;
    logic [W+7:0]          d2;
    logic [NKW-1:0]        relax_ext;
    logic [NKW-1:0]        noise_ext;
    logic [NKW-1:0]        newk_next;

    assign d2_full   = {{MAG_HALF{1'b0}}, c_plo_reg} + {c_phi_reg, {MAG_HALF{1'b0}}};
    assign d2        = d2_full[W+MAG_WIDTH-1:NOISE_SHIFT];
    assign relax_ext = {10'b0, c_d1_reg};
    assign noise_ext = {2'b0, d2};
    assign newk_next = {10'b0, c_k_reg}
                     + (c_rge_reg ? relax_ext : (NKW'(0) - relax_ext))
                     + (c_nneg_reg ? (NKW'(0) - noise_ext) : noise_ext);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_newk_reg <= newk_next;
            d_k_reg    <= c_k_reg;
            d_zero_reg <= c_zero_reg;
        end
    end

    // stage E: classify the new energy and set up the division
    logic                    e_valid_reg;
    logic [W+3:0]            e_num_reg;
    logic [W-1:0]            e_k_reg;
    logic [DPW-1:0]          e_pay_reg;
    logic                    newk_neg;
    logic                    newk_sat;
    status_t                 st_next;

    assign newk_neg = d_newk_reg[NKW-1];
    assign newk_sat = d_newk_reg[NKW-2:0] >= {5'b0, d_k_reg, 4'b0};

    always_comb
    begin
        priority if (d_zero_reg)
            st_next = STATUS_ZERO_K;
        else if (newk_neg)
            st_next = STATUS_NEG_K;
        else
            st_next = STATUS_OK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            e_valid_reg <= d_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e_num_reg <= d_newk_reg[W+3:0];
            e_k_reg   <= d_k_reg;
            e_pay_reg <= {st_next, (st_next == STATUS_OK) && newk_sat};
        end
    end

    // newK * 2^32 / K, quotient below 2^36
    logic                  q_valid;
    logic [QUOT_WIDTH-1:0] q_quot;
    logic [DPW-1:0]        q_pay;

    vrts_div_pipe #(
        .DW (W),
        .QW (QUOT_WIDTH),
        .PW (DPW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (e_valid_reg),
        .in_rem    (e_num_reg[W+3:4]),
        .in_low    ({e_num_reg[3:0], {FRAC_BITS{1'b0}}}),
        .in_div    (e_k_reg),
        .in_pay    (e_pay_reg),
        .out_valid (q_valid),
        .out_quot  (q_quot),
        .out_pay   (q_pay)
    );

    // root of the energy ratio
    logic                   s_valid;
    logic [SCALE_WIDTH-1:0] s_root;
    logic [DPW-1:0]         s_pay;

    vrts_sqrt_pipe #(
        .RW (SCALE_WIDTH),
        .PW (DPW)
    ) u_root_ratio (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (q_valid),
        .in_rad    (q_quot),
        .in_pay    (q_pay),
        .out_valid (s_valid),
        .out_root  (s_root),
        .out_pay   (s_pay)
    );

    // output register: saturate or zero the scale as the status asks
    logic [SCALE_WIDTH-1:0]  scale_reg;
    logic [STATUS_WIDTH-1:0] status_reg;
    logic [SCALE_WIDTH-1:0]  scale_next;

    always_comb
    begin
        priority if (s_pay[DPW-1:1] != STATUS_OK)
            scale_next = '0;
        else if (s_pay[0])
            scale_next = SCALE_MAX;
        else
            scale_next = s_root;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            scale_reg  <= scale_next;
            status_reg <= s_pay[DPW-1:1];
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0, status_reg, scale_reg};

`ifndef SYNTH
    a_err_zero_scale: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg != STATUS_OK) |-> (scale_reg == '0))
        else $error("error status with nonzero scale");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!adv) |=> ($stable(b_valid_reg) && $stable(e_valid_reg)))
        else $error("pipeline moved during stall");

    a_sat_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (s_valid && s_pay[0]) |-> (s_pay[DPW-1:1] == STATUS_OK))
        else $error("saturation flagged on error item");

    a_zero_k_status: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && d_valid_reg && d_zero_reg) |=> (e_pay_reg[DPW-1:1] == STATUS_ZERO_K))
        else $error("zero energy not flagged");
`endif

endmodule
